[sv/hill_pkg.sv]
// shared types, constants and arithmetic helpers for the 2x2 mod 26 hill cipher
package hill_pkg;

    // alphabet size and pad letter ('x')
    localparam logic [4:0] ALPHA      = 5'd26;
    localparam logic [4:0] PAD_LETTER = 5'd23;

    // configuration register indexes
    localparam logic [2:0] CFG_MODE_DECRYPT     = 3'd0;
    localparam logic [2:0] CFG_KEY_TOP_LEFT     = 3'd1;
    localparam logic [2:0] CFG_KEY_TOP_RIGHT    = 3'd2;
    localparam logic [2:0] CFG_KEY_BOTTOM_LEFT  = 3'd3;
    localparam logic [2:0] CFG_KEY_BOTTOM_RIGHT = 3'd4;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DET,
        ST_INV,
        ST_MAT,
        ST_MUL,
        ST_OUT0,
        ST_OUT1
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic hold;        // latch the first letter of a pair
        logic pair;        // latch the operand pair
        logic pad;         // pair the incoming letter with the pad letter
        logic det;         // form the two determinant products
        logic inv;         // determinant and its inverse
        logic mat;         // working matrix
        logic mul;         // matrix times pair
        logic sel_second;  // present the second result
    } t_dp_cmd;

    // reduce a 5 bit value mod 26
    function automatic logic [4:0] red26(input logic [4:0] v);
        red26 = (v >= ALPHA) ? (v - ALPHA) : v;
    endfunction

    // reduce a value below 832 mod 26 by conditional subtracts
    function automatic logic [4:0] mod26(input logic [9:0] v);
        logic [9:0] t;
        t = v;
        if (t >= 10'd416) t = t - 10'd416;
        if (t >= 10'd208) t = t - 10'd208;
        if (t >= 10'd104) t = t - 10'd104;
        if (t >= 10'd52)  t = t - 10'd52;
        if (t >= 10'd26)  t = t - 10'd26;
        mod26 = t[4:0];
    endfunction

    // additive inverse mod 26 of a reduced residue
    function automatic logic [4:0] neg26(input logic [4:0] v);
        neg26 = (v == 5'd0) ? 5'd0 : (ALPHA - v);
    endfunction

    // multiplicative inverse mod 26, zero where none exists
    function automatic logic [4:0] inv26(input logic [4:0] v);
        unique case (v)
            5'd1:    inv26 = 5'd1;
            5'd3:    inv26 = 5'd9;
            5'd5:    inv26 = 5'd21;
            5'd7:    inv26 = 5'd15;
            5'd9:    inv26 = 5'd3;
            5'd11:   inv26 = 5'd19;
            5'd15:   inv26 = 5'd7;
            5'd17:   inv26 = 5'd23;
            5'd19:   inv26 = 5'd11;
            5'd21:   inv26 = 5'd5;
            5'd23:   inv26 = 5'd17;
            5'd25:   inv26 = 5'd25;
            default: inv26 = 5'd0;
        endcase
    endfunction

endpackage

[sv/hill_dp.sv]
// datapath: key registers, operand pair, inverse key and mod 26 products
module hill_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [4:0]          i_cfg_data,
    input  logic [4:0]          i_letter,
    input  logic                i_last,
    input  hill_pkg::t_dp_cmd   i_cmd,
    output logic [4:0]          o_letter,
    output logic                o_last,
    output logic                o_key_error
);

    logic       r_mode;
    logic [4:0] r_key_a, r_key_b, r_key_c, r_key_d;
    logic [4:0] r_held, r_p0, r_p1;
    logic       r_last;
    logic [4:0] r_ad, r_bc, r_inv;
    logic       r_err;
    logic [4:0] r_m00, r_m01, r_m10, r_m11;
    logic [4:0] r_r0, r_r1;

    logic [4:0] letter_red;
    logic [4:0] ka, kb, kc, kd;
    logic [4:0] det;
    logic [5:0] sum0, sum1;

    // reduced operands
    assign letter_red = hill_pkg::red26(i_letter);
    assign ka = hill_pkg::red26(r_key_a);
    assign kb = hill_pkg::red26(r_key_b);
    assign kc = hill_pkg::red26(r_key_c);
    assign kd = hill_pkg::red26(r_key_d);

    // determinant mod 26 from the registered products
    assign det = (r_ad >= r_bc) ? (r_ad - r_bc) : (r_ad + hill_pkg::ALPHA - r_bc);

    // matrix row sums before the final reduction
    assign sum0 = {1'b0, hill_pkg::mod26({5'd0, r_m00} * {5'd0, r_p0})}
                + {1'b0, hill_pkg::mod26({5'd0, r_m01} * {5'd0, r_p1})};
    assign sum1 = {1'b0, hill_pkg::mod26({5'd0, r_m10} * {5'd0, r_p0})}
                + {1'b0, hill_pkg::mod26({5'd0, r_m11} * {5'd0, r_p1})};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_key_a <= 5'd1;
            r_key_b <= 5'd0;
            r_key_c <= 5'd0;
            r_key_d <= 5'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hill_pkg::CFG_MODE_DECRYPT:     r_mode  <= i_cfg_data[0];
                hill_pkg::CFG_KEY_TOP_LEFT:     r_key_a <= i_cfg_data;
                hill_pkg::CFG_KEY_TOP_RIGHT:    r_key_b <= i_cfg_data;
                hill_pkg::CFG_KEY_BOTTOM_LEFT:  r_key_c <= i_cfg_data;
                hill_pkg::CFG_KEY_BOTTOM_RIGHT: r_key_d <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // operand capture and the compute steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.hold) begin
            r_held <= letter_red;
        end
        if (i_cmd.pair) begin
            r_p0   <= i_cmd.pad ? letter_red : r_held;
            r_p1   <= i_cmd.pad ? hill_pkg::PAD_LETTER : letter_red;
            r_last <= i_last;
        end
        if (i_cmd.det) begin
            r_ad <= hill_pkg::mod26({5'd0, ka} * {5'd0, kd});
            r_bc <= hill_pkg::mod26({5'd0, kb} * {5'd0, kc});
        end
        if (i_cmd.inv) begin
            r_inv <= hill_pkg::inv26(det);
            r_err <= r_mode && (hill_pkg::inv26(det) == 5'd0);
        end
        if (i_cmd.mat) begin
            if (r_mode) begin
                // adjugate scaled by the determinant inverse
                r_m00 <= hill_pkg::mod26({5'd0, kd} * {5'd0, r_inv});
                r_m01 <= hill_pkg::mod26({5'd0, hill_pkg::neg26(kb)} * {5'd0, r_inv});
                r_m10 <= hill_pkg::mod26({5'd0, hill_pkg::neg26(kc)} * {5'd0, r_inv});
                r_m11 <= hill_pkg::mod26({5'd0, ka} * {5'd0, r_inv});
            end else begin
                r_m00 <= ka;
                r_m01 <= kb;
                r_m10 <= kc;
                r_m11 <= kd;
            end
        end
        if (i_cmd.mul) begin
            if (r_err) begin
                r_r0 <= 5'd0;
                r_r1 <= 5'd0;
            end else begin
                r_r0 <= (sum0 >= 6'd26) ? 5'(sum0 - 6'd26) : sum0[4:0];
                r_r1 <= (sum1 >= 6'd26) ? 5'(sum1 - 6'd26) : sum1[4:0];
            end
        end
    end

    // result select
    assign o_letter    = i_cmd.sel_second ? r_r1 : r_r0;
    assign o_last      = i_cmd.sel_second & r_last;
    assign o_key_error = r_err;

endmodule

[sv/hill_ctrl.sv]
// controller: pairing state, compute sequence and output handshake
module hill_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_last,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hill_pkg::t_dp_cmd   o_cmd
);

    hill_pkg::t_state r_state, n_state;
    logic             r_have_held, n_have_held;
    logic             in_acc, out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hill_pkg::ST_IDLE;
            r_have_held <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_have_held <= n_have_held;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_have_held = r_have_held;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            hill_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (r_have_held) begin
                        o_cmd.pair  = 1'b1;
                        n_have_held = 1'b0;
                        n_state     = hill_pkg::ST_DET;
                    end else if (i_in_last) begin
                        o_cmd.pair = 1'b1;
                        o_cmd.pad  = 1'b1;
                        n_state    = hill_pkg::ST_DET;
                    end else begin
                        o_cmd.hold  = 1'b1;
                        n_have_held = 1'b1;
                    end
                end
            end
            hill_pkg::ST_DET: begin
                o_cmd.det = 1'b1;
                n_state   = hill_pkg::ST_INV;
            end
            hill_pkg::ST_INV: begin
                o_cmd.inv = 1'b1;
                n_state   = hill_pkg::ST_MAT;
            end
            hill_pkg::ST_MAT: begin
                o_cmd.mat = 1'b1;
                n_state   = hill_pkg::ST_MUL;
            end
            hill_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = hill_pkg::ST_OUT0;
            end
            hill_pkg::ST_OUT0: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = hill_pkg::ST_OUT1;
            end
            hill_pkg::ST_OUT1: begin
                o_out_valid      = 1'b1;
                o_cmd.sel_second = 1'b1;
                if (i_out_ready) n_state = hill_pkg::ST_IDLE;
            end
            default: n_state = hill_pkg::ST_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    // input and output sides are never open in the same cycle
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is offered");

    // taking the first result moves to the second one
    a_first_then_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !o_cmd.sel_second) |=> (o_out_valid && o_cmd.sel_second))
        else $error("second result not offered after the first");

    // taking the second result reopens the input
    a_second_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_cmd.sel_second) |=> o_in_ready)
        else $error("input not reopened after a pair");

    // a last letter never leaves a letter held
    a_last_clears_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_last) |=> !r_have_held)
        else $error("letter held after the last letter");
`endif

endmodule

[sv/hill_cipher_2x2_mod26_top.sv]
// A result pair is offered after the second letter of a pair is accepted and the steps of
// operand capture, determinant products, inverse lookup, matrix and pair multiply run.
// Input is accepted only while idle, one letter per cycle for the first of a pair; a full
// pair: two accepts, four compute steps, two results; a padded last letter: one accept.
// Reset (synchronous, active low): encrypt mode, identity key, no letter held.
module hill_cipher_2x2_mod26_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write port
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [4:0] i_cfg_data,
    // letter input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [4:0] letter_in, [7:5] zero
    input  logic       s_axis_tlast,   // last_in
    // letter output stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [4:0] letter_out, [7:5] zero
    output logic       m_axis_tlast,   // last_out
    output logic       m_axis_tuser    // key_error
);

    hill_pkg::t_dp_cmd cmd;
    logic [4:0]        letter_out;

    // sequencing
    hill_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    // arithmetic
    hill_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_letter    (s_axis_tdata[4:0]),
        .i_last      (s_axis_tlast),
        .i_cmd       (cmd),
        .o_letter    (letter_out),
        .o_last      (m_axis_tlast),
        .o_key_error (m_axis_tuser)
    );

    assign m_axis_tdata = {3'b000, letter_out};

endmodule
